[rtl/pfi_pkg.sv]
// ----------------------------------------------------------------------------
// pfi_pkg: shared types and constants for the particle force integrator
// Fixed-point format, unit widths, mode and register codes, saturation helpers.
// ----------------------------------------------------------------------------
package pfi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_W     = 31 + FRAC_BITS;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = 32;

	localparam logic [DATA_W-1:0] S32_MAX    = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] ALPHA_TOP  = 32'(80) << FRAC_BITS;
	localparam logic [DATA_W-1:0] ALPHA_DIV  = 32'd80;
	localparam logic [15:0]       DAMP_RESET = 16'd4588;
	localparam logic [16:0]       DAMP_ONE   = 17'h1_0000;

	typedef enum logic [2:0] {
		MODE_ADD       = 3'd0,
		MODE_REPEL     = 3'd1,
		MODE_ATTRACT   = 3'd2,
		MODE_REPEL_P   = 3'd3,
		MODE_ATTRACT_P = 3'd4,
		MODE_CW        = 3'd5,
		MODE_CCW       = 3'd6,
		MODE_TICK      = 3'd7
	} mode_t;

	typedef enum logic {
		REG_DAMPING = 1'b0,
		REG_HOLD    = 1'b1
	} cfg_reg_t;

	function automatic logic signed [DATA_W-1:0] sat_add32(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return s[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] with_sign(
		input logic [30:0] m,
		input logic        neg
	);
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage

[rtl/pfi_sqrt.sv]
// ----------------------------------------------------------------------------
// pfi_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module pfi_sqrt import pfi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rad_q;
	logic [34:0]       rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [34:0]       rem_next;
	logic [34:0]       trial;

	assign rem_next = {rem_q[32:0], rad_q[RAD_W-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath carries no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/pfi_div.sv]
// ----------------------------------------------------------------------------
// pfi_div: iterative restoring divider
// Unsigned division whose quotient is known to fit in FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module pfi_div import pfi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DATA_W-1:0] den,
	output logic              done,
	output logic [QUO_W-1:0]  quo
);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [QUO_W-1:0]  nsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   trial;

	// The high part of the numerator is below the divisor, so only the low
	// QUO_W bits have to be brought down one at a time.
	assign trial = {rem_q, nsh_q[QUO_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DATA_W'(num[NUM_W-1:QUO_W]);
			nsh_q <= num[QUO_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			nsh_q <= {nsh_q[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DATA_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/particle_force_integrator.sv]
// ----------------------------------------------------------------------------
// particle_force_integrator: one 2-D particle with radial forces
// Damped Euler integration in signed Q16.16 under a multi-cycle sequencer.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and holds s_tready low until the
// result has been placed in the output register; that register lets the next
// transaction in while the result waits for m_tready. An add-force transaction
// goes straight from the accumulator update to the result. A tick spends most
// of its time waiting on the bit-serial square root for the speed and on the
// divider for the alpha; a frozen tick skips the velocity and position update,
// and a speed of 80 or more skips the divider. A radial transaction that misses
// runs only the square root for the distance; one that hits then makes up to
// three passes of the FRAC_BITS+1 step divider for the falloff and direction.
// A result stalled in the output register adds its wait to the next transaction.
// One registered 32x32 multiplier is shared by damping, squaring and the force products.
// ----------------------------------------------------------------------------
module particle_force_integrator import pfi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [15:0]  cfg_wdata,
	// Input stream. tdata from bit 0: arg_x, arg_y, reach, strength, one pad bit.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,
	// tuser: mode.
	input  logic [2:0]   s_tuser,
	// Output stream. tdata from bit 0: out_pos_x, out_pos_y, out_vel_x,
	// out_vel_y, trail_alpha, react_x, react_y.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata,
	// tuser: in_range.
	output logic         m_tuser
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ADDF, ST_TK_SUM, ST_TK_MX, ST_TK_MY, ST_TK_WY, ST_TK_POS,
		ST_SQX, ST_SQY, ST_SQS, ST_SQW, ST_TK_DIV, ST_PCT, ST_UX, ST_UXW, ST_UYW,
		ST_FX1, ST_FX2, ST_FY1, ST_FY2, ST_APPLY, ST_RESP
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] damping_q;
	logic        hold_q;

	// Particle state.
	logic signed [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;

	// Latched transaction.
	mode_t                    mode_q;
	logic signed [DATA_W-1:0] arg_x_q, arg_y_q, str_q;
	logic [30:0]              reach_q;

	// Working registers.
	logic [30:0]              mx_q, my_q;
	logic                     dneg_x_q, dneg_y_q;
	logic [RAD_W-1:0]         sq_q;
	logic [DATA_W-1:0]        dist_q;
	logic [QUO_W-1:0]         pct_q, ux_q, uy_q;
	logic [30:0]              fxm_q;
	logic                     hit_q;
	logic [7:0]               alpha_q;
	logic signed [DATA_W-1:0] react_x_q, react_y_q;

	// Shared multiplier.
	logic [DATA_W-1:0] mul_a, mul_b;
	logic [RAD_W-1:0]  prod_q;
	logic [RAD_W-1:0]  prod_shr;
	logic [30:0]       prod_sat;

	// Shared root and divider.
	logic              sqrt_start, sqrt_done;
	logic [RAD_W-1:0]  sqrt_rad;
	logic [ROOT_W-1:0] sqrt_root;
	logic              div_start, div_done;
	logic [NUM_W-1:0]  div_num;
	logic [DATA_W-1:0] div_den;
	logic [QUO_W-1:0]  div_quo;

	// Combinational helpers.
	logic signed [DATA_W:0]   diff_x, diff_y;
	logic [DATA_W:0]          dmag_x, dmag_y;
	logic [30:0]              clamp_x, clamp_y;
	logic [16:0]              damp_f;
	logic [DATA_W:0]          damp_m;
	logic [DATA_W-1:0]        speed_gap;
	logic [39:0]              alpha_prod;
	logic signed [DATA_W-1:0] fx, fy, gx, gy, rx, ry;

	assign s_tready = (state_q == ST_IDLE);

	assign damp_f   = DAMP_ONE - {1'b0, damping_q};
	assign damp_m   = prod_q[DATA_W+16:16];
	assign prod_shr = prod_q >> FRAC_BITS;
	assign prod_sat = (|prod_shr[RAD_W-1:31]) ? S32_MAX[30:0] : prod_shr[30:0];

	// Offset from the point to the particle, magnitude clamped to 2^31-1.
	assign diff_x = {pos_x_q[DATA_W-1], pos_x_q} - {arg_x_q[DATA_W-1], arg_x_q};
	assign diff_y = {pos_y_q[DATA_W-1], pos_y_q} - {arg_y_q[DATA_W-1], arg_y_q};
	assign dmag_x = diff_x[DATA_W] ? (DATA_W+1)'(-diff_x) : (DATA_W+1)'(diff_x);
	assign dmag_y = diff_y[DATA_W] ? (DATA_W+1)'(-diff_y) : (DATA_W+1)'(diff_y);
	assign clamp_x = (dmag_x > {2'b00, S32_MAX[30:0]}) ? S32_MAX[30:0] : dmag_x[30:0];
	assign clamp_y = (dmag_y > {2'b00, S32_MAX[30:0]}) ? S32_MAX[30:0] : dmag_y[30:0];

	// floor(255*t / 2^F) is later divided by 80 on the shared divider.
	assign speed_gap  = ALPHA_TOP - sqrt_root;
	assign alpha_prod = {speed_gap, 8'h00} - 40'(speed_gap);

	// Signed force components; fy comes straight from the last product.
	assign fx = with_sign(fxm_q, dneg_x_q ^ str_q[DATA_W-1]);
	assign fy = with_sign(prod_sat, dneg_y_q ^ str_q[DATA_W-1]);

	always_comb begin
		gx = fy;
		gy = -fx;
		rx = -fy;
		ry = fx;
		unique case (mode_q)
			MODE_REPEL: begin
				gx = fx;  gy = fy;  rx = '0;  ry = '0;
			end
			MODE_ATTRACT: begin
				gx = -fx; gy = -fy; rx = '0;  ry = '0;
			end
			MODE_REPEL_P: begin
				gx = fx;  gy = fy;  rx = -fx; ry = -fy;
			end
			MODE_ATTRACT_P: begin
				gx = -fx; gy = -fy; rx = fx;  ry = fy;
			end
			MODE_CW: begin
				gx = -fy; gy = fx;  rx = fy;  ry = -fx;
			end
			default: begin
				gx = fy;  gy = -fx; rx = -fy; ry = fx;
			end
		endcase
	end

	// Operand selection for the shared units.
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		sqrt_rad   = sq_q + prod_q;
		div_start  = 1'b0;
		div_num    = '0;
		div_den    = ALPHA_DIV;
		unique case (state_q)
			ST_TK_MX: begin
				mul_a = mag32(vel_x_q);
				mul_b = 32'(damp_f);
			end
			ST_TK_MY: begin
				mul_a = mag32(vel_y_q);
				mul_b = 32'(damp_f);
			end
			ST_SQX: begin
				mul_a = (mode_q == MODE_TICK) ? mag32(vel_x_q) : {1'b0, clamp_x};
				mul_b = mul_a;
			end
			ST_SQY: begin
				mul_a = (mode_q == MODE_TICK) ? mag32(vel_y_q) : {1'b0, my_q};
				mul_b = mul_a;
			end
			ST_SQS: sqrt_start = 1'b1;
			ST_SQW: begin
				if (sqrt_done) begin
					if (mode_q == MODE_TICK) begin
						div_start = (sqrt_root < ALPHA_TOP);
						div_num   = NUM_W'(alpha_prod >> FRAC_BITS);
						div_den   = ALPHA_DIV;
					end else begin
						div_start = (reach_q != '0) && (sqrt_root <= {1'b0, reach_q});
						div_num   = {31'(reach_q - sqrt_root[30:0]), FRAC_BITS'(0)};
						div_den   = {1'b0, reach_q};
					end
				end
			end
			ST_UX: begin
				div_start = (dist_q != '0);
				div_num   = {mx_q, FRAC_BITS'(0)};
				div_den   = dist_q;
			end
			ST_UXW: begin
				div_start = div_done;
				div_num   = {my_q, FRAC_BITS'(0)};
				div_den   = dist_q;
			end
			ST_FX1: begin
				mul_a = 32'(ux_q);
				mul_b = mag32(str_q);
			end
			ST_FX2, ST_FY2: begin
				mul_a = prod_shr[DATA_W-1:0];
				mul_b = 32'(pct_q);
			end
			ST_FY1: begin
				mul_a = 32'(uy_q);
				mul_b = mag32(str_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// The user must write the configuration only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q <= DAMP_RESET;
			hold_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_DAMPING: damping_q <= cfg_wdata;
				REG_HOLD:    hold_q    <= cfg_wdata[0];
			endcase
		end
	end

	// Sequencer, particle state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			vel_x_q  <= '0;
			vel_y_q  <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
		end else begin
			// In ST_RESP the output register is reloaded whenever it drains.
			if (m_tvalid && m_tready && state_q != ST_RESP)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q    <= mode_t'(s_tuser);
						arg_x_q   <= s_tdata[31:0];
						arg_y_q   <= s_tdata[63:32];
						reach_q   <= s_tdata[94:64];
						str_q     <= s_tdata[126:95];
						hit_q     <= 1'b0;
						alpha_q   <= '0;
						react_x_q <= '0;
						react_y_q <= '0;
						priority case (mode_t'(s_tuser))
							MODE_ADD:  state_q <= ST_ADDF;
							MODE_TICK: state_q <= ST_TK_SUM;
							default:   state_q <= ST_SQX;
						endcase
					end
				end
				ST_ADDF: begin
					acc_x_q <= sat_add32(acc_x_q, arg_x_q);
					acc_y_q <= sat_add32(acc_y_q, arg_y_q);
					state_q <= ST_RESP;
				end
				ST_TK_SUM: begin
					acc_x_q <= '0;
					acc_y_q <= '0;
					if (hold_q) begin
						state_q <= ST_SQX;
					end else begin
						vel_x_q <= sat_add32(vel_x_q, acc_x_q);
						vel_y_q <= sat_add32(vel_y_q, acc_y_q);
						state_q <= ST_TK_MX;
					end
				end
				ST_TK_MX: state_q <= ST_TK_MY;
				ST_TK_MY: begin
					vel_x_q <= vel_x_q[DATA_W-1] ? -damp_m[DATA_W-1:0] : damp_m[DATA_W-1:0];
					state_q <= ST_TK_WY;
				end
				ST_TK_WY: begin
					vel_y_q <= vel_y_q[DATA_W-1] ? -damp_m[DATA_W-1:0] : damp_m[DATA_W-1:0];
					state_q <= ST_TK_POS;
				end
				ST_TK_POS: begin
					pos_x_q <= sat_add32(pos_x_q, vel_x_q);
					pos_y_q <= sat_add32(pos_y_q, vel_y_q);
					state_q <= ST_SQX;
				end
				ST_SQX: begin
					// Radial items take the clamped offset here; ticks ignore it.
					mx_q     <= clamp_x;
					my_q     <= clamp_y;
					dneg_x_q <= diff_x[DATA_W];
					dneg_y_q <= diff_y[DATA_W];
					state_q  <= ST_SQY;
				end
				ST_SQY: begin
					sq_q    <= prod_q;
					state_q <= ST_SQS;
				end
				ST_SQS: begin
					sq_q    <= '0;
					state_q <= ST_SQW;
				end
				ST_SQW: begin
					if (sqrt_done) begin
						dist_q <= sqrt_root;
						if (mode_q == MODE_TICK) begin
							state_q <= (sqrt_root < ALPHA_TOP) ? ST_TK_DIV : ST_RESP;
						end else if (reach_q == '0) begin
							// Unlimited reach: full strength everywhere.
							hit_q   <= 1'b1;
							pct_q   <= QUO_W'(1) << FRAC_BITS;
							state_q <= ST_UX;
						end else if (sqrt_root <= {1'b0, reach_q}) begin
							hit_q   <= 1'b1;
							state_q <= ST_PCT;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_TK_DIV: begin
					if (div_done) begin
						alpha_q <= div_quo[7:0];
						state_q <= ST_RESP;
					end
				end
				ST_PCT: begin
					if (div_done) begin
						pct_q   <= div_quo;
						state_q <= ST_UX;
					end
				end
				ST_UX: begin
					// At zero distance the direction, and so the force, is zero.
					if (dist_q == '0) begin
						ux_q    <= '0;
						uy_q    <= '0;
						state_q <= ST_FX1;
					end else begin
						state_q <= ST_UXW;
					end
				end
				ST_UXW: begin
					if (div_done) begin
						ux_q    <= div_quo;
						state_q <= ST_UYW;
					end
				end
				ST_UYW: begin
					if (div_done) begin
						uy_q    <= div_quo;
						state_q <= ST_FX1;
					end
				end
				ST_FX1: state_q <= ST_FX2;
				ST_FX2: state_q <= ST_FY1;
				ST_FY1: begin
					fxm_q   <= prod_sat;
					state_q <= ST_FY2;
				end
				ST_FY2: state_q <= ST_APPLY;
				ST_APPLY: begin
					acc_x_q   <= sat_add32(acc_x_q, gx);
					acc_y_q   <= sat_add32(acc_y_q, gy);
					react_x_q <= rx;
					react_y_q <= ry;
					state_q   <= ST_RESP;
				end
				ST_RESP: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {react_y_q, react_x_q, alpha_q,
							vel_y_q, vel_x_q, pos_y_q, pos_x_q};
						m_tuser  <= hit_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pfi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sqrt_rad),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	pfi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

endmodule

[rtl/pfi_checker.sv]
// ----------------------------------------------------------------------------
// pfi_checker: port-level checks for the particle force integrator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pfi_checker import pfi_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [199:0] m_tdata,
	input logic         m_tuser
);

	// A stalled result transaction holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second transaction while busy");

	// A new result only appears after a period of work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without work");

	// A fading alpha only comes from ticks, which never report a hit.
	a_alpha_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[135:128] != 8'd0) |-> !m_tuser)
		else $error("alpha on a radial result");

endmodule

bind particle_force_integrator pfi_checker u_pfi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the particle force integrator
// Drives force, radial and tick transactions through the input stream, models
// the particle state bit for bit, and compares every output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import pfi_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_addr;
	logic [15:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	// Fields from bit 0: arg_x, arg_y, reach, strength, one pad bit.
	logic [127:0] s_tdata;
	// Field: mode.
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// Fields from bit 0: out_pos_x, out_pos_y, out_vel_x, out_vel_y,
	// trail_alpha, react_x, react_y.
	logic [199:0] m_tdata;
	// Field: in_range.
	logic         m_tuser;

	// One expected output transaction.
	typedef struct {
		logic [31:0] pos_x, pos_y, vel_x, vel_y;
		logic [7:0]  alpha;
		logic [31:0] react_x, react_y;
		logic        hit;
	} particle_out_t;

	particle_out_t expected_q[$];

	// Predicted particle state and register copies.
	longint pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
	longint damp_reg;
	bit     freeze;

	int  mismatches;
	int  results_seen;
	bit  idle_enable;
	int  hold_off;

	particle_force_integrator i_dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction helpers. Values live in longint so that 32-bit overflow
	// can be caught and saturated explicitly.
	// ------------------------------------------------------------------
	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp_sym(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483647) return -64'sd2147483647;
		return v;
	endfunction

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Direction component times strength times falloff, with symmetric saturation.
	function automatic longint radial_term(longint unsigned umag, bit neg, longint s,
		longint unsigned pct);
		longint unsigned m;
		m = ((umag * abs64(s)) >> FRAC_BITS) * pct >> FRAC_BITS;
		if (m > 64'd2147483647) m = 64'd2147483647;
		return (neg != (s < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint damped(longint v);
		longint unsigned m;
		m = (abs64(v) * (64'd65536 - damp_reg)) >> 16;
		return v < 0 ? sat32(-longint'(m)) : sat32(longint'(m));
	endfunction

	function automatic logic [7:0] fade_alpha(longint vx, longint vy);
		longint unsigned spd, top;
		spd = int_sqrt(abs64(vx) * abs64(vx) + abs64(vy) * abs64(vy));
		top = 64'd80 << FRAC_BITS;
		if (spd >= top) return 8'd0;
		return 8'((255 * (top - spd)) / top);
	endfunction

	// Advances the predicted particle by one input transaction and queues the result.
	function automatic void predict_particle(mode_t mode, logic [31:0] ax_b, logic [31:0] ay_b,
		logic [30:0] reach_b, logic [31:0] s_b);
		particle_out_t r;
		longint ax, ay, s, dx, dy, fx, fy, gx, gy, rx, ry;
		longint unsigned mx, my, span, pct, ux, uy, reach;
		ax = longint'($signed(ax_b));
		ay = longint'($signed(ay_b));
		s = longint'($signed(s_b));
		reach = reach_b;
		rx = 0; ry = 0;
		r.alpha = '0;
		r.hit = 1'b0;
		if (mode == MODE_ADD) begin
			acc_x = sat32(acc_x + ax);
			acc_y = sat32(acc_y + ay);
		end else if (mode == MODE_TICK) begin
			if (!freeze) begin
				vel_x = damped(sat32(vel_x + acc_x));
				vel_y = damped(sat32(vel_y + acc_y));
				pos_x = sat32(pos_x + vel_x);
				pos_y = sat32(pos_y + vel_y);
			end
			acc_x = 0;
			acc_y = 0;
			r.alpha = fade_alpha(vel_x, vel_y);
		end else begin
			dx = clamp_sym(pos_x - ax);
			dy = clamp_sym(pos_y - ay);
			mx = abs64(dx);
			my = abs64(dy);
			span = int_sqrt(mx * mx + my * my);
			pct = 0;
			if (reach == 0) begin
				r.hit = 1'b1;
				pct = 64'd1 << FRAC_BITS;
			end else if (span <= reach) begin
				r.hit = 1'b1;
				pct = ((reach - span) << FRAC_BITS) / reach;
			end
			if (r.hit) begin
				ux = 0; uy = 0;
				// A point sitting on the particle has no direction.
				if (span != 0) begin
					ux = (mx << FRAC_BITS) / span;
					uy = (my << FRAC_BITS) / span;
				end
				fx = radial_term(ux, dx < 0, s, pct);
				fy = radial_term(uy, dy < 0, s, pct);
				case (mode)
					MODE_REPEL: begin gx = fx; gy = fy; end
					MODE_ATTRACT: begin gx = -fx; gy = -fy; end
					MODE_REPEL_P: begin gx = fx; gy = fy; rx = -fx; ry = -fy; end
					MODE_ATTRACT_P: begin gx = -fx; gy = -fy; rx = fx; ry = fy; end
					MODE_CW: begin gx = -fy; gy = fx; rx = fy; ry = -fx; end
					default: begin gx = fy; gy = -fx; rx = -fy; ry = fx; end
				endcase
				acc_x = sat32(acc_x + gx);
				acc_y = sat32(acc_y + gy);
			end
		end
		r.pos_x = pos_x[31:0];
		r.pos_y = pos_y[31:0];
		r.vel_x = vel_x[31:0];
		r.vel_y = vel_y[31:0];
		r.react_x = 32'(sat32(rx));
		r.react_y = 32'(sat32(ry));
		expected_q.insert(expected_q.size(), r);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus side. Inputs change on the falling edge; the transaction is
	// taken at the rising edge where tvalid and tready are both high.
	// ------------------------------------------------------------------
	task automatic send_item(mode_t mode, logic [31:0] ax, logic [31:0] ay,
		logic [30:0] reach, logic [31:0] s);
		@(negedge clk);
		while (idle_enable && $urandom_range(99) < 28) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {1'b0, s, reach, ay, ax};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_particle(mode, ax, ay, reach, s);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Register writes happen only with nothing in flight.
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DAMPING) damp_reg = val;
		else freeze = val[0];
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (expected_q.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		// Every transaction yields a result, so an empty queue means idle;
		// a short margin covers the output register handover.
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			3: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stalls, plus a long hold-off when requested.
	// ------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= !(idle_enable && $urandom_range(99) < 28);
		end
	end

	always @(posedge clk) begin
		particle_out_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("output transaction with nothing expected");
				mismatches++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[31:0] !== e.pos_x) begin
					$error("out_pos_x expected %h actual %h", e.pos_x, m_tdata[31:0]);
					mismatches++;
				end
				if (m_tdata[63:32] !== e.pos_y) begin
					$error("out_pos_y expected %h actual %h", e.pos_y, m_tdata[63:32]);
					mismatches++;
				end
				if (m_tdata[95:64] !== e.vel_x) begin
					$error("out_vel_x expected %h actual %h", e.vel_x, m_tdata[95:64]);
					mismatches++;
				end
				if (m_tdata[127:96] !== e.vel_y) begin
					$error("out_vel_y expected %h actual %h", e.vel_y, m_tdata[127:96]);
					mismatches++;
				end
				if (m_tdata[135:128] !== e.alpha) begin
					$error("trail_alpha expected %h actual %h", e.alpha, m_tdata[135:128]);
					mismatches++;
				end
				if (m_tdata[167:136] !== e.react_x) begin
					$error("react_x expected %h actual %h", e.react_x, m_tdata[167:136]);
					mismatches++;
				end
				if (m_tdata[199:168] !== e.react_y) begin
					$error("react_y expected %h actual %h", e.react_y, m_tdata[199:168]);
					mismatches++;
				end
				if (m_tuser !== e.hit) begin
					$error("in_range expected %b actual %b", e.hit, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Extremes of each field, every mode, and the special cases: zero reach,
	// beyond reach, point on the particle, saturation.
	task automatic test_directed();
		send_item(MODE_TICK, 0, 0, 0, 0);
		send_item(MODE_REPEL, 0, 0, 31'h0001_0000, 32'h0001_0000);
		send_item(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 32'hffff_ffff);
		send_item(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0);
		send_item(MODE_REPEL, 32'h0010_0000, 32'h0008_0000, 0, 32'h0002_0000);
		send_item(MODE_ATTRACT, 32'h8000_0000, 32'h7fff_ffff, 31'h0001_0000,
			32'h0001_0000);
		send_item(MODE_REPEL_P, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff);
		send_item(MODE_ATTRACT_P, 32'h7fff_0000, 32'h7fff_0000, 31'h7fff_ffff,
			32'h8000_0000);
		send_item(MODE_CW, 0, 0, 31'h7fff_ffff, 32'h0003_0000);
		send_item(MODE_CCW, 32'h1234_5678, 32'hedcb_a987, 0, 32'hfffd_0000);
		send_item(MODE_TICK, 0, 0, 0, 0);
		send_item(MODE_ADD, 32'h0020_0000, 32'hffe0_0000, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0);
	endtask

	// Register extremes, including a frozen particle.
	task automatic test_registers();
		write_reg(REG_DAMPING, 16'd0);
		write_reg(REG_HOLD, 16'd1);
		send_item(MODE_ADD, 32'h0040_0000, 32'h0040_0000, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0);
		write_reg(REG_HOLD, 16'd0);
		send_item(MODE_ADD, 32'h0040_0000, 32'hffc0_0000, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0);
		write_reg(REG_DAMPING, 16'hffff);
		send_item(MODE_TICK, 0, 0, 0, 0);
		write_reg(REG_DAMPING, DAMP_RESET);
	endtask

	// Mostly short force-then-tick sequences with random content, and some
	// fully random transactions in between.
	task automatic test_random(int n);
		mode_t m;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) m = mode_t'($urandom_range(7));
			else if ($urandom_range(4) == 0) m = MODE_TICK;
			else if ($urandom_range(2) == 0) m = MODE_ADD;
			else m = mode_t'($urandom_range(1, 6));
			send_item(m, rand_word(), rand_word(),
				$urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(32'h0200_0000)),
				rand_word());
			if (i % 250 == 249) begin
				write_reg(REG_DAMPING, 16'($urandom));
				write_reg(REG_HOLD, 16'($urandom_range(1)));
			end
		end
	endtask

	// The receiver stalls for a long time while items keep coming, so the
	// output register fills and the input side backs up.
	task automatic test_backpressure();
		hold_off = 400;
		for (int i = 0; i < 6; i++)
			send_item(mode_t'($urandom_range(7)), rand_word(), rand_word(),
				31'($urandom_range(32'h0100_0000)), rand_word());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		idle_enable = 1'b0;
		hold_off = 0;
		mismatches = 0;
		results_seen = 0;
		pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; acc_x = 0; acc_y = 0;
		damp_reg = 4588;
		freeze = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The directed part runs with no idling at all.
		test_directed();
		idle_enable = 1'b1;
		test_registers();
		test_backpressure();
		test_random(1000);
		idle_enable = 1'b0;
		test_random(30);
		wait_drained();
		repeat (120) @(negedge clk);

		$display("Ran %0d output transactions over forces, radial modes and ticks,",
			results_seen);
		$display("with register changes, frozen ticks and a long output stall.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/pfi_pkg.sv
rtl/pfi_sqrt.sv
rtl/pfi_div.sv
rtl/particle_force_integrator.sv
rtl/pfi_checker.sv
test/tb_top.sv
